// File: rtl/core/mflsu_pkg.sv
// Shared types and constants of the memory-format load/store unit.
// Holds the channel payloads, the front-to-back command and the action codes.
// No dependencies.
package mflsu_pkg;

	// Input item kinds.
	localparam logic [1:0] KIND_INSN  = 2'd0;
	localparam logic [1:0] KIND_RDATA = 2'd1;
	localparam logic [1:0] KIND_RFW   = 2'd2;

	// Result actions.
	localparam logic [2:0] ACT_READ   = 3'd0;
	localparam logic [2:0] ACT_WRITE  = 3'd1;
	localparam logic [2:0] ACT_REG    = 3'd2;
	localparam logic [2:0] ACT_BRANCH = 3'd3;
	localparam logic [2:0] ACT_BAL    = 3'd4;
	localparam logic [2:0] ACT_CALL   = 3'd5;

	// Bus sizes.
	localparam logic [1:0] SZ_BYTE  = 2'd0;
	localparam logic [1:0] SZ_SHORT = 2'd1;
	localparam logic [1:0] SZ_WORD  = 2'd2;

	// Transfer types in opcode bits 5..3.
	localparam logic [2:0] TT_BYTE  = 3'd0;
	localparam logic [2:0] TT_SHORT = 3'd1;
	localparam logic [2:0] TT_WORD  = 3'd2;
	localparam logic [2:0] TT_LONG  = 3'd3;
	localparam logic [2:0] TT_TRIPLE_A = 3'd4;
	localparam logic [2:0] TT_TRIPLE_B = 3'd5;

	// Function selects in opcode bits 1..0.
	localparam logic [1:0] FN_BX   = 2'd0;
	localparam logic [1:0] FN_BALX = 2'd1;

	// Depth of the command queue between front and back.
	localparam int CMD_QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  opcode;
		logic [31:0] eff_addr;
		logic [4:0]  reg_index;
		logic [31:0] data_in;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] bus_addr;
		logic [1:0]  bus_size;
		logic [31:0] write_data;
		logic [4:0]  dest_reg;
		logic [31:0] reg_value;
		logic        overflow;
		logic        last;
	} out_item_t;

	// One classified operation; the back end expands it into its results.
	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] addr;
		logic [1:0]  size;
		logic [4:0]  base;
		logic [4:0]  dest;
		logic [31:0] value;
		logic [1:0]  last_word;
		logic        is_store;
		logic        ovf_chk;
		logic        rf_write;
	} cmd_t;

	// Index of the last word of a transfer type.
	function automatic logic [1:0] last_word_of(input logic [2:0] ttype);
		logic [1:0] lw;
		case (ttype)
			TT_BYTE, TT_SHORT, TT_WORD: lw = 2'd0;
			TT_LONG:                    lw = 2'd1;
			TT_TRIPLE_A, TT_TRIPLE_B:   lw = 2'd2;
			default:                    lw = 2'd3;
		endcase
		return lw;
	endfunction

endpackage

// File: rtl/core/mflsu_channels.sv
// Valid/ready channel interfaces of the load/store unit.
// Depends on mflsu_pkg for the payload types.
interface mflsu_in_if;
	import mflsu_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mflsu_out_if;
	import mflsu_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/mem_format_load_store_unit.sv
// Memory-format load/store unit. An accepted input beat passes the command queue,
// the back end's command register and the output register before its result beat
// is offered; each command then gives one beat per cycle while the output is not
// stalled. Inputs that cause no result are not queued. A two-entry queue decouples input
// from output. Reset clears the pending load, the queue, the output register and
// the register file valid bits at once; unwritten registers read as zero.
module mem_format_load_store_unit #(
	parameter int REG_COUNT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	mflsu_in_if.sink    in_ch,
	mflsu_out_if.source out_ch
);
	import mflsu_pkg::*;

	logic push;
	logic pop;
	logic fifo_full;
	logic fifo_empty;
	cmd_t push_data;
	cmd_t head;

	// Classification of incoming beats.
	mflsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.fifo_full(fifo_full),
		.push     (push),
		.push_data(push_data)
	);

	// Decoupling queue.
	mflsu_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (fifo_full),
		.pop      (pop),
		.head     (head),
		.empty    (fifo_empty)
	);

	// Execution and result beats.
	mflsu_back #(
		.REG_COUNT(REG_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fifo_empty(fifo_empty),
		.head      (head),
		.pop       (pop),
		.out_ch    (out_ch)
	);
endmodule

// File: rtl/core/mflsu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mflsu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// File: rtl/core/mflsu_front.sv
// Front end: accepts input beats, tracks the pending load and classifies each
// beat into a command for the back end. Depends on mflsu_pkg and the channels.
module mflsu_front (
	input  logic                clk,
	input  logic                arst_n,
	mflsu_in_if.sink            in_ch,
	input  logic                fifo_full,
	output logic                push,
	output mflsu_pkg::cmd_t     push_data
);
	import mflsu_pkg::*;

	logic [2:0] pcnt_q;
	logic [1:0] pword_q;
	logic [4:0] pbase_q;
	logic [1:0] psize_q;
	logic       psgn_q;

	logic [2:0] pcnt_d;
	logic [1:0] pword_d;
	logic [4:0] pbase_d;
	logic [1:0] psize_d;
	logic       psgn_d;

	logic       in_fire;
	logic       want_push;
	cmd_t       cmd;
	in_item_t   it;
	logic [2:0] ttype;
	logic       sgn;
	logic [31:0] ext;

	assign in_ch.ready = !fifo_full;
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign it          = in_ch.data;
	assign ttype       = it.opcode[5:3];
	assign sgn         = it.opcode[6];

	// Extension of returned read data to the pending load size.
	always_comb begin
		case (psize_q)
			SZ_BYTE:  ext = {{24{psgn_q & it.data_in[7]}}, it.data_in[7:0]};
			SZ_SHORT: ext = {{16{psgn_q & it.data_in[15]}}, it.data_in[15:0]};
			default:  ext = it.data_in;
		endcase
	end

	// Classification and next pending-load state.
	always_comb begin
		cmd       = '0;
		want_push = 1'b0;
		pcnt_d    = pcnt_q;
		pword_d   = pword_q;
		pbase_d   = pbase_q;
		psize_d   = psize_q;
		psgn_d    = psgn_q;
		case (it.kind)
			KIND_INSN: begin
				want_push = 1'b1;
				pcnt_d    = 3'd0;
				if (it.opcode[2]) begin
					if (it.opcode[3]) begin
						// Load address into a register.
						cmd.action   = ACT_REG;
						cmd.base     = it.reg_index;
						cmd.dest     = it.reg_index;
						cmd.value    = it.eff_addr;
						cmd.rf_write = 1'b1;
					end else begin
						cmd.addr = it.eff_addr;
						case (it.opcode[1:0])
							FN_BX:   cmd.action = ACT_BRANCH;
							FN_BALX: begin
								cmd.action = ACT_BAL;
								cmd.dest   = it.reg_index;
							end
							default: cmd.action = ACT_CALL;
						endcase
					end
				end else if (it.opcode[1]) begin
					cmd.action   = ACT_WRITE;
					cmd.addr     = it.eff_addr;
					cmd.base     = it.reg_index;
					cmd.is_store = 1'b1;
					if (ttype inside {TT_BYTE, TT_SHORT}) begin
						cmd.size    = ttype[1:0];
						cmd.ovf_chk = sgn;
					end else begin
						cmd.size      = SZ_WORD;
						cmd.last_word = last_word_of(ttype);
					end
				end else begin
					cmd.action    = ACT_READ;
					cmd.addr      = it.eff_addr;
					cmd.last_word = last_word_of(ttype);
					pcnt_d        = {1'b0, last_word_of(ttype)} + 3'd1;
					pword_d       = 2'd0;
					pbase_d       = it.reg_index;
					if (ttype inside {TT_BYTE, TT_SHORT}) begin
						cmd.size = ttype[1:0];
						psize_d  = ttype[1:0];
						psgn_d   = sgn;
					end else begin
						cmd.size = SZ_WORD;
						psize_d  = SZ_WORD;
						psgn_d   = 1'b0;
					end
				end
			end
			KIND_RDATA: begin
				// Returned data fills the next word of the pending group.
				if (pcnt_q != 3'd0) begin
					want_push    = 1'b1;
					cmd.action   = ACT_REG;
					cmd.base     = pbase_q | {3'b000, pword_q};
					cmd.dest     = pbase_q | {3'b000, pword_q};
					cmd.value    = ext;
					cmd.rf_write = 1'b1;
					pword_d      = pword_q + 2'd1;
					pcnt_d       = pcnt_q - 3'd1;
				end
			end
			KIND_RFW: begin
				want_push    = 1'b1;
				cmd.action   = ACT_REG;
				cmd.base     = it.reg_index;
				cmd.dest     = it.reg_index;
				cmd.value    = it.data_in;
				cmd.rf_write = 1'b1;
			end
			default: want_push = 1'b0;
		endcase
	end

	assign push      = in_fire && want_push;
	assign push_data = cmd;

	// Pending-load state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q  <= '0;
			pword_q <= '0;
			pbase_q <= '0;
			psize_q <= '0;
			psgn_q  <= 1'b0;
		end else if (in_fire) begin
			pcnt_q  <= pcnt_d;
			pword_q <= pword_d;
			pbase_q <= pbase_d;
			psize_q <= psize_d;
			psgn_q  <= psgn_d;
		end
	end
endmodule

// File: rtl/core/mflsu_cmd_fifo.sv
// Short command queue between the front and back ends.
// Depends on mflsu_pkg for the command type and depth.
module mflsu_cmd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mflsu_pkg::cmd_t     push_data,
	output logic                full,
	input  logic                pop,
	output mflsu_pkg::cmd_t     head,
	output logic                empty
);
	import mflsu_pkg::*;

	localparam int PW = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(CMD_QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(CMD_QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(CMD_QUEUE_DEPTH);

	cmd_t          entries [CMD_QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == DEPTH_C);
	assign empty = (cnt_q == '0);
	assign head  = entries[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("command pushed into a full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("command popped from an empty queue");
`endif
endmodule

// File: rtl/core/mflsu_back.sv
// Back end: expands each command into result beats, owns the register file
// and the output register. Depends on mflsu_pkg, mflsu_ram and the channels.
module mflsu_back #(
	parameter int REG_COUNT = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fifo_empty,
	input  mflsu_pkg::cmd_t     head,
	output logic                pop,
	mflsu_out_if.source         out_ch
);
	import mflsu_pkg::*;

	localparam int RIDX_W = $clog2(REG_COUNT);
	localparam logic [6:0] RC_W = 7'(REG_COUNT);

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_RUN  = 2'b10
	} bk_state_t;

	bk_state_t             state_q;
	cmd_t                  cur_q;
	logic [1:0]            k_q;
	out_item_t             out_q;
	logic                  out_valid_q;
	logic [REG_COUNT-1:0]  rf_valid_q;
	logic                  rd_valid_q;

	logic                  out_free;
	logic                  emit;
	logic                  rd_en;
	logic [RIDX_W-1:0]     rd_addr;
	logic                  wr_en;
	logic [RIDX_W-1:0]     wr_addr;
	logic [31:0]           rd_data;
	logic [31:0]           sval;
	logic                  ovf;
	logic                  is_last;
	out_item_t             res;

	// Register number reduced modulo the file size; the index is below twice it.
	function automatic logic [RIDX_W-1:0] slot(input logic [4:0] idx);
		logic [6:0] w;
		w = {2'b00, idx};
		if (w >= RC_W) begin
			w = w - RC_W;
		end
		return w[RIDX_W-1:0];
	endfunction

	mflsu_ram #(
		.WIDTH(32),
		.DEPTH(REG_COUNT)
	) u_rf (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(cur_q.value),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign out_free = !out_valid_q || out_ch.ready;
	assign emit     = (state_q == BK_RUN) && out_free;
	assign pop      = (state_q == BK_IDLE) && !fifo_empty;
	assign is_last  = (k_q == cur_q.last_word);
	assign wr_en    = emit && cur_q.rf_write;
	assign wr_addr  = slot(cur_q.base);

	// Register reads: first word on pop, each further word as the previous is sent.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = slot(head.base);
		if (pop) begin
			rd_en = head.is_store;
		end else if (emit && !is_last) begin
			rd_en   = cur_q.is_store;
			rd_addr = slot(cur_q.base | {3'b000, k_q + 2'd1});
		end
	end

	// Store data: an entry never written reads as zero.
	assign sval = rd_valid_q ? rd_data : '0;

	always_comb begin
		case (cur_q.size)
			SZ_BYTE:  ovf = !((&sval[31:7]) || !(|sval[31:7]));
			SZ_SHORT: ovf = !((&sval[31:15]) || !(|sval[31:15]));
			default:  ovf = 1'b0;
		endcase
	end

	// Result beat for the current word.
	always_comb begin
		res            = '0;
		res.action     = cur_q.action;
		res.bus_addr   = cur_q.addr + {28'd0, k_q, 2'b00};
		res.bus_size   = cur_q.size;
		res.dest_reg   = cur_q.dest;
		res.reg_value  = cur_q.value;
		res.overflow   = cur_q.ovf_chk && ovf;
		res.last       = is_last;
		if (cur_q.is_store) begin
			case (cur_q.size)
				SZ_BYTE:  res.write_data = {24'd0, sval[7:0]};
				SZ_SHORT: res.write_data = {16'd0, sval[15:0]};
				default:  res.write_data = sval;
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			k_q     <= '0;
		end else begin
			case (state_q)
				BK_IDLE: begin
					if (pop) begin
						state_q <= BK_RUN;
						k_q     <= '0;
					end
				end
				BK_RUN: begin
					if (emit) begin
						if (is_last) begin
							state_q <= BK_IDLE;
						end else begin
							k_q <= k_q + 2'd1;
						end
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	// Valid bits of the register file and of the last read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				rf_valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= rf_valid_q[rd_addr];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

`ifndef SYNTHESIS
	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en)) else $error("register file read and written together");
	a_word_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_RUN) |-> (k_q <= cur_q.last_word))
		else $error("word index beyond the group");
	a_pop_runs: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == BK_RUN)) else $error("popped command not started");
`endif
endmodule

// File: tb/mem_format_load_store_unit_test.sv
// Self-checking testbench for the memory-format load/store unit.
// Drives instruction, read-data and register-write beats and checks every result.
// Depends on mflsu_pkg, the channel interfaces and mem_format_load_store_unit.
module mem_format_load_store_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import mflsu_pkg::*;

	// Codes the package leaves out.
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam logic [2:0] TT_QUAD_A  = 3'd6;
	localparam logic [2:0] TT_QUAD_B  = 3'd7;
	localparam logic [1:0] FN_CALLX_A = 2'd2;
	localparam logic [1:0] FN_CALLX_B = 2'd3;
	localparam logic DIR_LOAD  = 1'b0;
	localparam logic DIR_STORE = 1'b1;
	localparam logic NOT_LDA   = 1'b0;
	localparam logic IS_LDA    = 1'b1;

	// Opcode bit positions.
	localparam int OP_STORE_BIT  = 1;
	localparam int OP_FUNC_BIT   = 2;
	localparam int OP_LDA_BIT    = 3;
	localparam int OP_SIGNED_BIT = 6;

	logic clk;
	logic arst_n;

	mflsu_in_if  in_ch();
	mflsu_out_if out_ch();

	mem_format_load_store_unit #(
		.REG_COUNT(32)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Shadow state of the unit.
	logic [31:0] rf_copy [32];
	int          load_left;
	logic [1:0]  load_word;
	logic [4:0]  load_base;
	logic [1:0]  load_size;
	logic        load_signed;

	out_item_t lsu_results_q[$];
	int        mismatch_count = 0;
	int        busy_beats = 0;
	int        sender_idle_pct = 0;
	int        recv_stall_pct = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int words_of(logic [2:0] ttype);
		case (ttype)
			TT_BYTE, TT_SHORT, TT_WORD: return 1;
			TT_LONG:                    return 2;
			TT_TRIPLE_A, TT_TRIPLE_B:   return 3;
			default:                    return 4;
		endcase
	endfunction

	function automatic out_item_t result_of(logic [2:0] action, logic [31:0] addr,
			logic [1:0] size, logic [31:0] wdata, logic [4:0] dreg, logic [31:0] rval,
			logic ovf);
		out_item_t r;
		r.action     = action;
		r.bus_addr   = addr;
		r.bus_size   = size;
		r.write_data = wdata;
		r.dest_reg   = dreg;
		r.reg_value  = rval;
		r.overflow   = ovf;
		r.last       = 1'b0;
		return r;
	endfunction

	// Works out the results of one accepted beat, updates the shadow state and
	// queues the results. Returns how many there are.
	function automatic int lsu_results_of(in_item_t b);
		out_item_t  res[$];
		logic [2:0] ttype;
		logic       sgn;
		logic [31:0] v;
		logic [4:0] dst;
		logic [1:0] size;
		logic       ovf;
		int         cnt;
		ttype = b.opcode[5:3];
		sgn   = b.opcode[OP_SIGNED_BIT];
		case (b.kind)
			KIND_INSN: begin
				// Any instruction drops a load still waiting for data.
				load_left = 0;
				if (b.opcode[OP_FUNC_BIT]) begin
					if (b.opcode[OP_LDA_BIT]) begin
						rf_copy[b.reg_index] = b.eff_addr;
						res.push_back(result_of(ACT_REG, '0, SZ_BYTE, '0, b.reg_index,
							b.eff_addr, 1'b0));
					end else begin
						case (b.opcode[1:0])
							FN_BX: res.push_back(result_of(ACT_BRANCH, b.eff_addr, SZ_BYTE,
								'0, '0, '0, 1'b0));
							FN_BALX: res.push_back(result_of(ACT_BAL, b.eff_addr, SZ_BYTE,
								'0, b.reg_index, '0, 1'b0));
							default: res.push_back(result_of(ACT_CALL, b.eff_addr, SZ_BYTE,
								'0, '0, '0, 1'b0));
						endcase
					end
				end else if (b.opcode[OP_STORE_BIT]) begin
					v = rf_copy[b.reg_index];
					if (ttype == TT_BYTE) begin
						ovf = sgn && v[31:7] != '0 && v[31:7] != '1;
						res.push_back(result_of(ACT_WRITE, b.eff_addr, SZ_BYTE,
							{24'd0, v[7:0]}, '0, '0, ovf));
					end else if (ttype == TT_SHORT) begin
						ovf = sgn && v[31:15] != '0 && v[31:15] != '1;
						res.push_back(result_of(ACT_WRITE, b.eff_addr, SZ_SHORT,
							{16'd0, v[15:0]}, '0, '0, ovf));
					end else begin
						cnt = words_of(ttype);
						for (int k = 0; k < cnt; k++)
							res.push_back(result_of(ACT_WRITE, b.eff_addr + 32'(4 * k),
								SZ_WORD, rf_copy[b.reg_index | 5'(k)], '0, '0, 1'b0));
					end
				end else begin
					cnt  = words_of(ttype);
					size = (ttype == TT_BYTE) ? SZ_BYTE :
						(ttype == TT_SHORT) ? SZ_SHORT : SZ_WORD;
					for (int k = 0; k < cnt; k++)
						res.push_back(result_of(ACT_READ, b.eff_addr + 32'(4 * k), size,
							'0, '0, '0, 1'b0));
					load_left   = cnt;
					load_word   = 2'd0;
					load_base   = b.reg_index;
					load_size   = size;
					load_signed = (size != SZ_WORD) ? sgn : 1'b0;
				end
			end
			KIND_RDATA: begin
				// Returned data fills the next register of the group.
				if (load_left != 0) begin
					v   = b.data_in;
					dst = load_base | {3'd0, load_word};
					if (load_size == SZ_BYTE) begin
						v = {24'd0, v[7:0]};
						if (load_signed && v[7]) v[31:8] = '1;
					end else if (load_size == SZ_SHORT) begin
						v = {16'd0, v[15:0]};
						if (load_signed && v[15]) v[31:16] = '1;
					end
					rf_copy[dst] = v;
					res.push_back(result_of(ACT_REG, '0, SZ_BYTE, '0, dst, v, 1'b0));
					load_word = load_word + 2'd1;
					load_left--;
				end
			end
			KIND_RFW: begin
				rf_copy[b.reg_index] = b.data_in;
				res.push_back(result_of(ACT_REG, '0, SZ_BYTE, '0, b.reg_index,
					b.data_in, 1'b0));
			end
			default: ;
		endcase
		if (res.size() > 0) res[res.size() - 1].last = 1'b1;
		foreach (res[i]) lsu_results_q.push_back(res[i]);
		return res.size();
	endfunction

	// Beat builders. Bits that do not matter are random.
	function automatic logic [7:0] transfer_opcode(logic sgn, logic [2:0] ttype,
			logic store);
		return {1'($urandom), sgn, ttype, 1'b0, store, 1'($urandom)};
	endfunction

	function automatic logic [7:0] function_opcode(logic lda, logic [1:0] sel);
		return {4'($urandom), lda, 1'b1, sel};
	endfunction

	function automatic in_item_t insn_beat(logic [7:0] opcode, logic [31:0] addr,
			logic [4:0] idx);
		in_item_t b;
		b.kind      = KIND_INSN;
		b.opcode    = opcode;
		b.eff_addr  = addr;
		b.reg_index = idx;
		b.data_in   = $urandom;
		return b;
	endfunction

	function automatic in_item_t core_beat(logic [1:0] kind, logic [4:0] idx,
			logic [31:0] value);
		in_item_t b;
		b.kind      = kind;
		b.opcode    = 8'($urandom);
		b.eff_addr  = $urandom;
		b.reg_index = idx;
		b.data_in   = value;
		return b;
	endfunction

	function automatic in_item_t noise_beat();
		in_item_t b;
		b.kind      = 2'($urandom_range(3));
		b.opcode    = 8'($urandom);
		b.eff_addr  = $urandom;
		b.reg_index = 5'($urandom);
		b.data_in   = $urandom;
		return b;
	endfunction

	// Addresses near the top wrap within a group.
	function automatic logic [31:0] rand_addr();
		if ($urandom_range(99) < 15) return {28'hFFFFFFF, 4'($urandom)};
		return $urandom;
	endfunction

	// Register values that fit a signed byte or short in two cases of three.
	function automatic logic [31:0] rand_reg_value();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(2))
			0: return r;
			1: return {{24{r[7]}}, r[7:0]};
			default: return {{16{r[15]}}, r[15:0]};
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%08h, expected 0x%08h", name, got, want));
	endtask

	// Sends one beat, idling first at the current rate, then predicts it.
	task automatic send_beat(in_item_t b);
		int made;
		forever begin
			@(negedge clk);
			if ($urandom_range(99) < sender_idle_pct) in_ch.valid <= 1'b0;
			else break;
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= b;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		made = lsu_results_of(b);
		if (made > 0) busy_beats++;
	endtask

	// Receiver stalls at the current rate.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Each result beat against the oldest prediction.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (lsu_results_q.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected, action %0d",
					out_ch.data.action));
			end else begin
				want = lsu_results_q.pop_front();
				check_field("action", 32'(out_ch.data.action), 32'(want.action));
				check_field("bus_addr", out_ch.data.bus_addr, want.bus_addr);
				check_field("bus_size", 32'(out_ch.data.bus_size), 32'(want.bus_size));
				check_field("write_data", out_ch.data.write_data, want.write_data);
				check_field("dest_reg", 32'(out_ch.data.dest_reg), 32'(want.dest_reg));
				check_field("reg_value", out_ch.data.reg_value, want.reg_value);
				check_field("overflow", 32'(out_ch.data.overflow), 32'(want.overflow));
				check_field("last", 32'(out_ch.data.last), 32'(want.last));
			end
		end
	end

	// Core writes with values at the edges of the signed byte and short ranges.
	task automatic test_register_writes();
		send_beat(core_beat(KIND_RFW, 5'd0, 32'hFFFF_FFFF));
		send_beat(core_beat(KIND_RFW, 5'd31, 32'h0000_0080));
		send_beat(core_beat(KIND_RFW, 5'd1, 32'hFFFF_8000));
	endtask

	// Load-address and the three kinds of control transfer.
	task automatic test_functions();
		send_beat(insn_beat(function_opcode(IS_LDA, 2'($urandom)), 32'hFFFF_FFFC, 5'd3));
		send_beat(insn_beat(function_opcode(NOT_LDA, FN_BX), 32'h0000_0000, 5'd17));
		send_beat(insn_beat(function_opcode(NOT_LDA, FN_BALX), 32'h8000_0000, 5'd31));
		send_beat(insn_beat(function_opcode(NOT_LDA, FN_CALLX_A), 32'h1234_5678, 5'd9));
		send_beat(insn_beat(function_opcode(NOT_LDA, FN_CALLX_B), 32'h7FFF_FFFF, 5'd0));
	endtask

	// Byte and short stores in and out of range, and a quad store that wraps.
	task automatic test_stores();
		send_beat(insn_beat(transfer_opcode(1'b1, TT_BYTE, DIR_STORE), 32'h10, 5'd31));
		send_beat(insn_beat(transfer_opcode(1'b0, TT_BYTE, DIR_STORE), 32'h11, 5'd31));
		send_beat(insn_beat(transfer_opcode(1'b1, TT_SHORT, DIR_STORE), 32'h12, 5'd1));
		send_beat(insn_beat(transfer_opcode(1'b1, TT_BYTE, DIR_STORE), 32'h13, 5'd1));
		send_beat(insn_beat(transfer_opcode(1'b1, TT_BYTE, DIR_STORE), 32'h14, 5'd0));
		send_beat(insn_beat(transfer_opcode(1'b0, TT_QUAD_B, DIR_STORE), 32'hFFFF_FFF8,
			5'd0));
	endtask

	// A sign-extended byte load, then a quad load whose group folds onto itself.
	task automatic test_loads();
		send_beat(insn_beat(transfer_opcode(1'b1, TT_BYTE, DIR_LOAD), 32'h20, 5'd4));
		send_beat(core_beat(KIND_RDATA, 5'($urandom), 32'h1234_5680));
		send_beat(insn_beat(transfer_opcode(1'b0, TT_QUAD_A, DIR_LOAD), 32'hFFFF_FFF4,
			5'd29));
		send_beat(core_beat(KIND_RDATA, 5'($urandom), 32'hFFFF_FFFF));
		send_beat(core_beat(KIND_RDATA, 5'($urandom), 32'h0000_0000));
		send_beat(core_beat(KIND_RDATA, 5'($urandom), 32'hA5A5_5A5A));
		send_beat(core_beat(KIND_RDATA, 5'($urandom), 32'h5A5A_A5A5));
	endtask

	// Core write during a load, a load cut short, stray data and the spare kind.
	task automatic test_special_cases();
		send_beat(insn_beat(transfer_opcode(1'b1, TT_LONG, DIR_LOAD), 32'h40, 5'd8));
		send_beat(core_beat(KIND_RFW, 5'd5, 32'h0000_1234));
		send_beat(core_beat(KIND_RDATA, 5'($urandom), 32'h0000_CAFE));
		send_beat(insn_beat(function_opcode(NOT_LDA, FN_BX), 32'h50, 5'd2));
		send_beat(core_beat(KIND_RDATA, 5'($urandom), 32'hDEAD_BEEF));
		send_beat(core_beat(KIND_SPARE, 5'($urandom), $urandom));
	endtask

	// Random traffic; loads followed by their data are the most common item.
	task automatic random_traffic(int beats);
		int         target;
		int         choice;
		int         cnt;
		logic [2:0] ttype;
		target = busy_beats + beats;
		while (busy_beats < target) begin
			choice = $urandom_range(99);
			ttype  = 3'($urandom_range(7));
			if (choice < 45) begin
				send_beat(insn_beat(transfer_opcode(1'($urandom), ttype, DIR_LOAD),
					rand_addr(), 5'($urandom)));
				cnt = words_of(ttype);
				for (int k = 0; k < cnt; k++) begin
					if ($urandom_range(99) < 8)
						send_beat(core_beat(KIND_RFW, 5'($urandom), rand_reg_value()));
					if ($urandom_range(99) < 4) break;
					send_beat(core_beat(KIND_RDATA, 5'($urandom), $urandom));
				end
			end else if (choice < 65) begin
				send_beat(insn_beat(transfer_opcode(1'($urandom), ttype, DIR_STORE),
					rand_addr(), 5'($urandom)));
			end else if (choice < 77) begin
				send_beat(core_beat(KIND_RFW, 5'($urandom), rand_reg_value()));
			end else if (choice < 87) begin
				send_beat(insn_beat(function_opcode(1'($urandom), 2'($urandom)),
					rand_addr(), 5'($urandom)));
			end else begin
				send_beat(noise_beat());
			end
		end
	endtask

	// The random part under each idling pattern in turn.
	task automatic test_random_traffic();
		int idle_pct [4]  = '{0, 82, 0, 26};
		int stall_pct [4] = '{0, 0, 82, 26};
		for (int p = 0; p < 4; p++) begin
			sender_idle_pct = idle_pct[p];
			recv_stall_pct  = stall_pct[p];
			random_traffic(50);
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data  = '0;
		arst_n      = 1'b0;
		foreach (rf_copy[i]) rf_copy[i] = '0;
		load_left   = 0;
		load_word   = '0;
		load_base   = '0;
		load_size   = '0;
		load_signed = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_register_writes();
		test_functions();
		test_stores();
		test_loads();
		test_special_cases();
		test_random_traffic();

		// Drain, then give the back end time to show any extra beat.
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (lsu_results_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/mflsu_pkg.sv
rtl/core/mflsu_channels.sv
rtl/core/mflsu_ram.sv
rtl/core/mflsu_front.sv
rtl/core/mflsu_cmd_fifo.sv
rtl/core/mflsu_back.sv
rtl/core/mem_format_load_store_unit.sv
tb/mem_format_load_store_unit_test.sv
